// ===== src/opl_pkg.sv =====
// Shared types, constants and helper functions for the ordered process list.
`timescale 1ns / 1ps

package opl_pkg;

    // Sizing of the list store.
    localparam int CAPACITY   = 32;
    localparam int PID_BITS   = 16;
    localparam int SLOT_BITS  = $clog2(CAPACITY);
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);

    // Fixed widths of the id fields on the stream ports.
    localparam int PORT_PID_BITS = 16;

    // Request kinds carried in the input tuser.
    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_INSERT = 2'd2,
        REQ_DUMP   = 2'd3
    } req_t;

    // Result status codes carried in the output tuser.
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_EMPTY     = 2'd3
    } status_t;

    // Which single result a request ends with.
    typedef enum logic [2:0] {
        RES_OK_PID,
        RES_OK_NPID,
        RES_NOT_FOUND,
        RES_FULL_PID,
        RES_FULL_NPID,
        RES_EMPTY
    } res_code_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SEARCH,
        S_APPEND,
        S_DELETE,
        S_INS_LINK,
        S_INS_SPLICE,
        S_DUMP,
        S_RESULT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      latch_req;
        logic      rd_head;
        logic      rd_next;
        logic      capture_match;
        logic      do_append;
        logic      do_delete;
        logic      do_ins_link;
        logic      do_ins_splice;
        logic      res_set;
        res_code_t res_code;
        logic      out_pending;
        logic      out_dump;
    } opl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        req_t req;
        logic full;
        logic empty;
        logic id_match;
        logic walk_last;
        logic parent_is_tail;
        logic out_free;
    } opl_stat_t;

    // Take a port id in its low PID_BITS bits.
    function automatic logic [PID_BITS-1:0] pid_from_port(input logic [PORT_PID_BITS-1:0] p);
        logic [PID_BITS+PORT_PID_BITS-1:0] wide;
        wide = {{PID_BITS{1'b0}}, p};
        return wide[PID_BITS-1:0];
    endfunction

    // Present a stored id on the port width.
    function automatic logic [PORT_PID_BITS-1:0] pid_to_port(input logic [PID_BITS-1:0] p);
        logic [PID_BITS+PORT_PID_BITS-1:0] wide;
        wide = {{PORT_PID_BITS{1'b0}}, p};
        return wide[PORT_PID_BITS-1:0];
    endfunction

endpackage

// ===== src/opl_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module opl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds while no new read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/opl_ctrl.sv =====
// Controller state machine that sequences each list request.
`timescale 1ns / 1ps

module opl_ctrl
    import opl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  opl_stat_t stat,
    output opl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.req)
                    REQ_APPEND: state_next = stat.full ? S_RESULT : S_APPEND;
                    REQ_DELETE: state_next = stat.empty ? S_RESULT : S_SEARCH;
                    REQ_INSERT: state_next = (stat.full || stat.empty) ? S_RESULT : S_SEARCH;
                    REQ_DUMP:   state_next = stat.empty ? S_RESULT : S_DUMP;
                    default:    state_next = S_RESULT;
                endcase
            end
            S_SEARCH:
            begin
                if (stat.id_match)
                begin
                    state_next = (stat.req == REQ_DELETE) ? S_DELETE : S_INS_LINK;
                end
                else if (stat.walk_last)
                begin
                    state_next = S_RESULT;
                end
            end
            S_APPEND:     state_next = S_RESULT;
            S_DELETE:     state_next = S_RESULT;
            S_INS_LINK:   state_next = stat.parent_is_tail ? S_RESULT : S_INS_SPLICE;
            S_INS_SPLICE: state_next = S_RESULT;
            S_DUMP:
            begin
                if (stat.out_free && stat.walk_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Output logic.
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.latch_req = in_valid;
            end
            S_DECODE:
            begin
                case (stat.req)
                    REQ_APPEND:
                    begin
                        if (stat.full)
                        begin
                            cmd.res_set  = 1'b1;
                            cmd.res_code = RES_FULL_PID;
                        end
                    end
                    REQ_DELETE:
                    begin
                        if (stat.empty)
                        begin
                            cmd.res_set  = 1'b1;
                            cmd.res_code = RES_NOT_FOUND;
                        end
                        else
                        begin
                            cmd.rd_head = 1'b1;
                        end
                    end
                    REQ_INSERT:
                    begin
                        // Fullness is checked before the parent is searched.
                        if (stat.full)
                        begin
                            cmd.res_set  = 1'b1;
                            cmd.res_code = RES_FULL_NPID;
                        end
                        else if (stat.empty)
                        begin
                            cmd.res_set  = 1'b1;
                            cmd.res_code = RES_NOT_FOUND;
                        end
                        else
                        begin
                            cmd.rd_head = 1'b1;
                        end
                    end
                    REQ_DUMP:
                    begin
                        if (stat.empty)
                        begin
                            cmd.res_set  = 1'b1;
                            cmd.res_code = RES_EMPTY;
                        end
                        else
                        begin
                            cmd.rd_head = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.res_set  = 1'b1;
                        cmd.res_code = RES_EMPTY;
                    end
                endcase
            end
            S_SEARCH:
            begin
                if (stat.id_match)
                begin
                    cmd.capture_match = 1'b1;
                end
                else if (stat.walk_last)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = RES_NOT_FOUND;
                end
                else
                begin
                    cmd.rd_next = 1'b1;
                end
            end
            S_APPEND:
            begin
                cmd.do_append = 1'b1;
                cmd.res_set   = 1'b1;
                cmd.res_code  = RES_OK_PID;
            end
            S_DELETE:
            begin
                cmd.do_delete = 1'b1;
                cmd.res_set   = 1'b1;
                cmd.res_code  = RES_OK_PID;
            end
            S_INS_LINK:
            begin
                cmd.do_ins_link = 1'b1;
                cmd.res_set     = 1'b1;
                cmd.res_code    = RES_OK_NPID;
            end
            S_INS_SPLICE:
            begin
                cmd.do_ins_splice = 1'b1;
            end
            S_DUMP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_dump = 1'b1;
                    cmd.rd_next  = !stat.walk_last;
                end
            end
            S_RESULT:
            begin
                cmd.out_pending = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== src/opl_dp.sv =====
// Datapath: link stores, list pointers, free map, link walker and result register.
`timescale 1ns / 1ps

module opl_dp
    import opl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  opl_cmd_t                 cmd,
    output opl_stat_t                stat,
    input  logic [1:0]               req_in,
    input  logic [PORT_PID_BITS-1:0] pid_in,
    input  logic [PORT_PID_BITS-1:0] new_pid,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               out_status,
    output logic [PORT_PID_BITS-1:0] out_pid,
    output logic                     out_last
);

    // Latched request.
    req_t                  req_reg;
    logic [PID_BITS-1:0]   pid_reg;
    logic [PID_BITS-1:0]   npid_reg;

    // List pointers and occupancy.
    logic [SLOT_BITS-1:0]  head_reg;
    logic [SLOT_BITS-1:0]  tail_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [CAPACITY-1:0]   free_map_reg;

    // Walker state and the captured match.
    logic [SLOT_BITS-1:0]  cur_reg;
    logic [COUNT_BITS-1:0] k_reg;
    logic [SLOT_BITS-1:0]  match_slot_reg;
    logic [SLOT_BITS-1:0]  match_prev_reg;
    logic [SLOT_BITS-1:0]  match_next_reg;
    logic [SLOT_BITS-1:0]  alloc_reg;

    // Pending single result and the output register.
    status_t                  res_status_reg;
    logic [PORT_PID_BITS-1:0] res_pid_reg;
    logic                     out_valid_reg;
    logic [1:0]               out_status_reg;
    logic [PORT_PID_BITS-1:0] out_pid_reg;
    logic                     out_last_reg;

    // Memory ports.
    logic                  rd_en;
    logic [SLOT_BITS-1:0]  rd_addr;
    logic [PID_BITS-1:0]   id_rdata;
    logic [SLOT_BITS-1:0]  next_rdata;
    logic [SLOT_BITS-1:0]  prev_rdata;
    logic                  id_we;
    logic [SLOT_BITS-1:0]  id_waddr;
    logic [PID_BITS-1:0]   id_wdata;
    logic                  next_we;
    logic [SLOT_BITS-1:0]  next_waddr;
    logic [SLOT_BITS-1:0]  next_wdata;
    logic                  prev_we;
    logic [SLOT_BITS-1:0]  prev_waddr;
    logic [SLOT_BITS-1:0]  prev_wdata;

    logic [SLOT_BITS-1:0]  free_slot;
    logic                  full;
    logic                  empty;
    logic                  walk_last;
    logic                  out_free;

    // Occupancy and walker status.
    assign full      = (count_reg == COUNT_BITS'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign walk_last = ((k_reg + COUNT_BITS'(1)) == count_reg);
    assign out_free  = !out_valid_reg || out_ready;

    assign stat.req            = req_reg;
    assign stat.full           = full;
    assign stat.empty          = empty;
    assign stat.id_match       = (id_rdata == pid_reg);
    assign stat.walk_last      = walk_last;
    assign stat.parent_is_tail = (match_slot_reg == tail_reg);
    assign stat.out_free       = out_free;

    // Lowest-numbered free slot.
    always_comb
    begin
        free_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (free_map_reg[i])
            begin
                free_slot = SLOT_BITS'(i);
            end
        end
    end

    // All three stores are read at the same slot: the head, or the next link just read.
    assign rd_en   = cmd.rd_head || cmd.rd_next;
    assign rd_addr = cmd.rd_head ? head_reg : next_rdata;

    // Write port selection for the three stores.
    always_comb
    begin
        id_we      = 1'b0;
        id_waddr   = free_slot;
        id_wdata   = pid_reg;
        next_we    = 1'b0;
        next_waddr = tail_reg;
        next_wdata = free_slot;
        prev_we    = 1'b0;
        prev_waddr = free_slot;
        prev_wdata = tail_reg;
        if (cmd.do_append)
        begin
            id_we   = 1'b1;
            next_we = !empty;
            prev_we = !empty;
        end
        else if (cmd.do_delete)
        begin
            next_we    = (match_slot_reg != head_reg);
            next_waddr = match_prev_reg;
            next_wdata = match_next_reg;
            prev_we    = (match_slot_reg != tail_reg);
            prev_waddr = match_next_reg;
            prev_wdata = match_prev_reg;
        end
        else if (cmd.do_ins_link)
        begin
            id_we      = 1'b1;
            id_wdata   = npid_reg;
            next_we    = 1'b1;
            next_waddr = match_slot_reg;
            next_wdata = free_slot;
            prev_we    = 1'b1;
            prev_waddr = free_slot;
            prev_wdata = match_slot_reg;
        end
        else if (cmd.do_ins_splice)
        begin
            next_we    = 1'b1;
            next_waddr = alloc_reg;
            next_wdata = match_next_reg;
            prev_we    = 1'b1;
            prev_waddr = match_next_reg;
            prev_wdata = alloc_reg;
        end
    end

    opl_ram #(.WIDTH(PID_BITS), .DEPTH(CAPACITY)) u_id_store (
        .clk     (clk),
        .wr_en   (id_we),
        .wr_addr (id_waddr),
        .wr_data (id_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (id_rdata)
    );

    opl_ram #(.WIDTH(SLOT_BITS), .DEPTH(CAPACITY)) u_next_link (
        .clk     (clk),
        .wr_en   (next_we),
        .wr_addr (next_waddr),
        .wr_data (next_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (next_rdata)
    );

    opl_ram #(.WIDTH(SLOT_BITS), .DEPTH(CAPACITY)) u_prev_link (
        .clk     (clk),
        .wr_en   (prev_we),
        .wr_addr (prev_waddr),
        .wr_data (prev_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (prev_rdata)
    );

    // Request latch, walker position and captured match (payload, no reset).
    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            req_reg  <= req_t'(req_in);
            pid_reg  <= pid_from_port(pid_in);
            npid_reg <= pid_from_port(new_pid);
        end
        if (rd_en)
        begin
            cur_reg <= rd_addr;
            k_reg   <= cmd.rd_head ? '0 : k_reg + COUNT_BITS'(1);
        end
        if (cmd.capture_match)
        begin
            match_slot_reg <= cur_reg;
            match_prev_reg <= prev_rdata;
            match_next_reg <= next_rdata;
        end
        if (cmd.do_ins_link)
        begin
            alloc_reg <= free_slot;
        end
    end

    // List pointers, count and free map.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            free_map_reg <= '1;
        end
        else if (cmd.do_append)
        begin
            free_map_reg[free_slot] <= 1'b0;
            if (empty)
            begin
                head_reg <= free_slot;
            end
            tail_reg  <= free_slot;
            count_reg <= count_reg + COUNT_BITS'(1);
        end
        else if (cmd.do_delete)
        begin
            if (match_slot_reg == head_reg)
            begin
                head_reg <= match_next_reg;
            end
            if (match_slot_reg == tail_reg)
            begin
                tail_reg <= match_prev_reg;
            end
            free_map_reg[match_slot_reg] <= 1'b1;
            count_reg <= count_reg - COUNT_BITS'(1);
        end
        else if (cmd.do_ins_link)
        begin
            free_map_reg[free_slot] <= 1'b0;
            if (match_slot_reg == tail_reg)
            begin
                tail_reg <= free_slot;
            end
            count_reg <= count_reg + COUNT_BITS'(1);
        end
    end

    // Pending result of a single-result request.
    always_ff @(posedge clk)
    begin
        if (cmd.res_set)
        begin
            case (cmd.res_code)
                RES_OK_PID:
                begin
                    res_status_reg <= STAT_OK;
                    res_pid_reg    <= pid_to_port(pid_reg);
                end
                RES_OK_NPID:
                begin
                    res_status_reg <= STAT_OK;
                    res_pid_reg    <= pid_to_port(npid_reg);
                end
                RES_NOT_FOUND:
                begin
                    res_status_reg <= STAT_NOT_FOUND;
                    res_pid_reg    <= pid_to_port(pid_reg);
                end
                RES_FULL_PID:
                begin
                    res_status_reg <= STAT_FULL;
                    res_pid_reg    <= pid_to_port(pid_reg);
                end
                RES_FULL_NPID:
                begin
                    res_status_reg <= STAT_FULL;
                    res_pid_reg    <= pid_to_port(npid_reg);
                end
                RES_EMPTY:
                begin
                    res_status_reg <= STAT_EMPTY;
                    res_pid_reg    <= '0;
                end
                default:
                begin
                    res_status_reg <= STAT_EMPTY;
                    res_pid_reg    <= '0;
                end
            endcase
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_pending || cmd.out_dump)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload: a dumped entry or the pending result.
    always_ff @(posedge clk)
    begin
        if (cmd.out_dump)
        begin
            out_status_reg <= STAT_OK;
            out_pid_reg    <= pid_to_port(id_rdata);
            out_last_reg   <= walk_last;
        end
        else if (cmd.out_pending)
        begin
            out_status_reg <= res_status_reg;
            out_pid_reg    <= res_pid_reg;
            out_last_reg   <= 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_pid    = out_pid_reg;
    assign out_last   = out_last_reg;

endmodule

// ===== src/ordered_process_list.sv =====
// Top level of the ordered process list: stream ports, controller and datapath.
`timescale 1ns / 1ps
//
// Ordered list of process ids kept in a 32-slot linked store.
// The slave stream carries one request: tuser is the request kind (append,
// delete, insert-after, dump), tdata holds the id and the new id.
// The master stream carries results: tuser is the status, tdata the id,
// tlast marks the final result of a request. Append, delete and insert
// give one result; dump gives one result per entry, head to tail.
// One request is served at a time; tready is high only while idle.
// A request refused at once (full list, empty list) goes from decode straight to
// the result state; a good append first writes the store and the pointers.
// Delete and insert-after walk the links through the store read port, one entry
// per cycle, stop at the first match or at the tail, then relink if it was found.
// Dump presents its entries head to tail, one per cycle while the receiver takes
// them. tready returns high once the final result is in the output register.
// A stalled receiver holds the result register; a dump pauses its walk
// until the register frees, and no result is lost.
// Reset empties the list and frees every slot; no clearing pass is needed.
//

module ordered_process_list
    import opl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] pid_in, [31:16] new_pid
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] pid_out
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast
);

    opl_cmd_t  cmd;
    opl_stat_t stat;

    // Request sequencing.
    opl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Store, pointers and result register.
    opl_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .req_in     (s_axis_tuser),
        .pid_in     (s_axis_tdata[15:0]),
        .new_pid    (s_axis_tdata[31:16]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (m_axis_tuser),
        .out_pid    (m_axis_tdata),
        .out_last   (m_axis_tlast)
    );

endmodule

// ===== verif/ordered_process_list_test.sv =====
// Self-checking testbench for the ordered process list with a built-in list predictor.
`timescale 1ns / 1ps

module ordered_process_list_test;
    import opl_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = CAPACITY + 30;
    localparam int LONG_HOLD   = 400;
    localparam int HOLD_AFTER  = 40;
    localparam int PHASE_ITEMS = 50;
    localparam int NUM_PHASES  = 6;
    localparam int NUM_ROWS    = 23;

    // Phase kinds of the random part.
    localparam int MODE_MIXED  = 0;
    localparam int MODE_GROW   = 1;
    localparam int MODE_SHRINK = 2;

    typedef struct packed {
        status_t     status;
        logic [15:0] pid;
        logic        last;
    } list_result_t;

    typedef struct packed {
        req_t        req;
        logic [15:0] pid;
        logic [15:0] npid;
        logic        fixed;
        status_t     status;
        logic [15:0] pid_out;
        logic        last;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // Predicted list contents, kept as slots with forward and backward links.
    logic [15:0]          lst_id   [CAPACITY];
    int                   lst_next [CAPACITY];
    int                   lst_prev [CAPACITY];
    bit   [CAPACITY-1:0]  lst_free;
    int                   lst_head;
    int                   lst_tail;
    int                   lst_count;

    list_result_t model_out[$];
    list_result_t pending_results[$];
    list_result_t mon_want;
    logic [15:0]  id_pool [4];
    int           error_count  = 0;
    int           results_seen = 0;
    int           cycle_count  = 0;
    bit           stall_on     = 1'b1;
    bit           hold_done    = 1'b0;

    // Directed requests; expected results are typed in where they are obvious.
    dir_row_t dir_rows [NUM_ROWS] = '{
        '{REQ_DUMP,   16'h0000, 16'h0000, 1'b1, STAT_EMPTY,     16'h0000, 1'b1},
        '{REQ_DELETE, 16'h1234, 16'h0000, 1'b1, STAT_NOT_FOUND, 16'h1234, 1'b1},
        '{REQ_INSERT, 16'h0005, 16'h0006, 1'b1, STAT_NOT_FOUND, 16'h0005, 1'b1},
        '{REQ_APPEND, 16'h0000, 16'hFFFF, 1'b1, STAT_OK,        16'h0000, 1'b1},
        '{REQ_APPEND, 16'hFFFF, 16'h0000, 1'b1, STAT_OK,        16'hFFFF, 1'b1},
        '{REQ_INSERT, 16'hFFFF, 16'hA5A5, 1'b1, STAT_OK,        16'hA5A5, 1'b1},
        '{REQ_INSERT, 16'h0000, 16'h5A5A, 1'b1, STAT_OK,        16'h5A5A, 1'b1},
        '{REQ_APPEND, 16'h0000, 16'h0000, 1'b1, STAT_OK,        16'h0000, 1'b1},
        '{REQ_DUMP,   16'h0000, 16'h0000, 1'b0, STAT_OK,        16'h0000, 1'b0},
        '{REQ_INSERT, 16'h0000, 16'h0001, 1'b1, STAT_OK,        16'h0001, 1'b1},
        '{REQ_DELETE, 16'h0000, 16'h0000, 1'b1, STAT_OK,        16'h0000, 1'b1},
        '{REQ_DUMP,   16'hFFFF, 16'hFFFF, 1'b0, STAT_OK,        16'h0000, 1'b0},
        '{REQ_DELETE, 16'hA5A5, 16'h0000, 1'b1, STAT_OK,        16'hA5A5, 1'b1},
        '{REQ_DELETE, 16'h0000, 16'h0000, 1'b1, STAT_OK,        16'h0000, 1'b1},
        '{REQ_DELETE, 16'h0000, 16'h0000, 1'b1, STAT_NOT_FOUND, 16'h0000, 1'b1},
        '{REQ_INSERT, 16'h0000, 16'hFFFF, 1'b1, STAT_NOT_FOUND, 16'h0000, 1'b1},
        '{REQ_DUMP,   16'h0000, 16'h0000, 1'b0, STAT_OK,        16'h0000, 1'b0},
        '{REQ_DELETE, 16'h5A5A, 16'h0000, 1'b1, STAT_OK,        16'h5A5A, 1'b1},
        '{REQ_DELETE, 16'hFFFF, 16'h0000, 1'b1, STAT_OK,        16'hFFFF, 1'b1},
        '{REQ_DELETE, 16'h0001, 16'h0000, 1'b1, STAT_OK,        16'h0001, 1'b1},
        '{REQ_DUMP,   16'h0000, 16'h0000, 1'b1, STAT_EMPTY,     16'h0000, 1'b1},
        '{REQ_APPEND, 16'h8001, 16'h7FFE, 1'b1, STAT_OK,        16'h8001, 1'b1},
        '{REQ_DUMP,   16'h0000, 16'h0000, 1'b0, STAT_OK,        16'h0000, 1'b0}
    };

    ordered_process_list u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Free-running clock.
    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    // Empty list with every slot free, as after reset.
    function automatic void list_clear();
        for (int i = 0; i < CAPACITY; i++)
        begin
            lst_id[i]   = '0;
            lst_next[i] = 0;
            lst_prev[i] = 0;
        end
        lst_free  = '1;
        lst_head  = 0;
        lst_tail  = 0;
        lst_count = 0;
    endfunction

    // A new entry takes the lowest-numbered free slot.
    function automatic int take_free_slot();
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (lst_free[i])
            begin
                lst_free[i] = 1'b0;
                return i;
            end
        end
        return 0;
    endfunction

    // Walk from the head and stop at the first entry holding the id.
    function automatic bit locate_id(input logic [15:0] pid, output int slot);
        int cur;
        cur  = lst_head;
        slot = 0;
        for (int k = 0; k < lst_count; k++)
        begin
            if (lst_id[cur] == pid)
            begin
                slot = cur;
                return 1'b1;
            end
            cur = lst_next[cur];
        end
        return 1'b0;
    endfunction

    function automatic void note_result(input status_t st, input logic [15:0] pid,
                                        input logic last);
        list_result_t r;
        r.status = st;
        r.pid    = pid;
        r.last   = last;
        model_out.push_back(r);
    endfunction

    // Apply one request to the predicted list and note the results it gives.
    function automatic void list_apply(input req_t req, input logic [15:0] pid,
                                       input logic [15:0] npid);
        int s;
        int p;
        int n;
        int cur;
        case (req)
            REQ_APPEND:
            begin
                if (lst_count >= CAPACITY)
                    note_result(STAT_FULL, pid, 1'b1);
                else
                begin
                    s = take_free_slot();
                    lst_id[s] = pid;
                    if (lst_count == 0)
                        lst_head = s;
                    else
                    begin
                        lst_next[lst_tail] = s;
                        lst_prev[s] = lst_tail;
                    end
                    lst_tail = s;
                    lst_count++;
                    note_result(STAT_OK, pid, 1'b1);
                end
            end
            REQ_DELETE:
            begin
                if (!locate_id(pid, s))
                    note_result(STAT_NOT_FOUND, pid, 1'b1);
                else
                begin
                    p = lst_prev[s];
                    n = lst_next[s];
                    if (s == lst_head)
                        lst_head = n;
                    else
                        lst_next[p] = n;
                    if (s == lst_tail)
                        lst_tail = p;
                    else
                        lst_prev[n] = p;
                    lst_free[s] = 1'b1;
                    lst_count--;
                    note_result(STAT_OK, pid, 1'b1);
                end
            end
            REQ_INSERT:
            begin
                // Fullness wins over a missing parent.
                if (lst_count >= CAPACITY)
                    note_result(STAT_FULL, npid, 1'b1);
                else if (!locate_id(pid, p))
                    note_result(STAT_NOT_FOUND, pid, 1'b1);
                else
                begin
                    s = take_free_slot();
                    lst_id[s]   = npid;
                    lst_prev[s] = p;
                    if (p == lst_tail)
                        lst_tail = s;
                    else
                    begin
                        n = lst_next[p];
                        lst_next[s] = n;
                        lst_prev[n] = s;
                    end
                    lst_next[p] = s;
                    lst_count++;
                    note_result(STAT_OK, npid, 1'b1);
                end
            end
            default:
            begin
                if (lst_count == 0)
                    note_result(STAT_EMPTY, 16'h0000, 1'b1);
                else
                begin
                    cur = lst_head;
                    for (int k = 0; k < lst_count; k++)
                    begin
                        note_result(STAT_OK, lst_id[cur], (k == lst_count - 1));
                        cur = lst_next[cur];
                    end
                end
            end
        endcase
    endfunction

    // Id of a random entry that is in the list now.
    function automatic logic [15:0] pick_listed();
        int cur;
        int k;
        cur = lst_head;
        k   = $urandom_range(0, lst_count - 1);
        for (int i = 0; i < k; i++)
            cur = lst_next[cur];
        return lst_id[cur];
    endfunction

    // Fresh id: often from a small pool so that duplicates occur.
    function automatic logic [15:0] fresh_id();
        if ($urandom_range(0, 9) < 4)
            return id_pool[$urandom_range(0, 3)];
        return 16'($urandom_range(0, 65535));
    endfunction

    // Draw one random request, weighted by the kind of phase.
    function automatic void pick_request(input int mode, output req_t req,
                                         output logic [15:0] pid, output logic [15:0] npid);
        int r;
        int app_lim;
        int del_lim;
        int ins_lim;
        case (mode)
            MODE_GROW:   begin app_lim = 45; del_lim = 55; ins_lim = 90; end
            MODE_SHRINK: begin app_lim = 10; del_lim = 75; ins_lim = 85; end
            default:     begin app_lim = 30; del_lim = 55; ins_lim = 85; end
        endcase
        r    = $urandom_range(0, 99);
        pid  = fresh_id();
        npid = fresh_id();
        if (r < app_lim)
            req = REQ_APPEND;
        else if (r < ins_lim)
        begin
            req = (r < del_lim) ? REQ_DELETE : REQ_INSERT;
            // Mostly aim at an id that is present, sometimes at a missing one.
            if (lst_count > 0 && $urandom_range(0, 5) != 0)
                pid = pick_listed();
        end
        else
            req = REQ_DUMP;
    endfunction

    // Offer one request, wait for acceptance, then predict its results.
    task automatic send_request(input req_t req, input logic [15:0] pid,
                                input logic [15:0] npid, input bit fixed,
                                input list_result_t fixed_res, input int gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {npid, pid};
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        model_out.delete();
        list_apply(req, pid, npid);
        if (fixed)
            pending_results.push_back(fixed_res);
        else
            foreach (model_out[i])
                pending_results.push_back(model_out[i]);
    endtask

    // Request source: reset, directed table, then random phases.
    initial
    begin : stimulus
        list_result_t fixed_res;
        req_t         rq;
        logic [15:0]  pa;
        logic [15:0]  pb;
        int           phase_modes [NUM_PHASES];
        bit           idle_on;

        phase_modes = '{MODE_GROW, MODE_GROW, MODE_SHRINK,
                        MODE_MIXED, MODE_GROW, MODE_SHRINK};
        list_clear();
        foreach (id_pool[i])
            id_pool[i] = 16'($urandom_range(0, 65535));
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= REQ_APPEND;
        rst_n         <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        foreach (dir_rows[i])
        begin
            fixed_res.status = dir_rows[i].status;
            fixed_res.pid    = dir_rows[i].pid_out;
            fixed_res.last   = dir_rows[i].last;
            send_request(dir_rows[i].req, dir_rows[i].pid, dir_rows[i].npid,
                         dir_rows[i].fixed, fixed_res, $urandom_range(0, 12));
        end

        // Random part: grow to full, drain, and mix, with idle and busy stretches.
        fixed_res = '0;
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            idle_on = (ph % 3 != 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick_request(phase_modes[ph], rq, pa, pb);
                send_request(rq, pa, pb, 1'b0, fixed_res,
                             idle_on ? $urandom_range(0, 12) : 0);
            end
        end
        s_axis_tvalid <= 1'b0;

        // Let every expected result arrive, then watch for stray ones.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("PASS ordered_process_list");
        else
            $display("FAIL ordered_process_list");
        $finish;
    end

    // Result sink: random stalls, stall-free stretches and one long hold-off.
    initial
    begin : sink
        int gap;
        m_axis_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 40) == 0)
                stall_on = !stall_on;
            gap = stall_on ? $urandom_range(0, 12) : 0;
            if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                gap       = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen <= results_seen + 1;
            if (pending_results.size() == 0)
            begin
                $error("result with no request pending: status %0d pid %h last %0d",
                       m_axis_tuser, m_axis_tdata, m_axis_tlast);
                error_count++;
            end
            else
            begin
                mon_want = pending_results.pop_front();
                if (m_axis_tuser !== mon_want.status)
                begin
                    $error("status: expected %0d, got %0d", mon_want.status, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata !== mon_want.pid)
                begin
                    $error("pid_out: expected %h, got %h", mon_want.pid, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tlast !== mon_want.last)
                begin
                    $error("last: expected %0d, got %0d", mon_want.last, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL ordered_process_list");
            $finish;
        end
    end

endmodule

// ===== ordered_process_list.f =====
src/opl_pkg.sv
src/opl_ram.sv
src/opl_ctrl.sv
src/opl_dp.sv
src/ordered_process_list.sv
verif/ordered_process_list_test.sv
